/* hdl/tac_pkg.sv */
// Package for the touch affine calibration block.
// Register indexes, register reset values and solver quantity codes.
// No dependencies.
package tac_pkg;

  localparam int CFG_INDEX_BITS = 3;

  localparam logic [CFG_INDEX_BITS-1:0] REG_TOUCH_0   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TOUCH_1   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TOUCH_2   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DISPLAY_0 = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DISPLAY_1 = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DISPLAY_2 = 3'd5;

  localparam logic [31:0] RST_TOUCH_0   = 32'd3097377;
  localparam logic [31:0] RST_TOUCH_1   = 32'd13948930;
  localparam logic [31:0] RST_TOUCH_2   = 32'd8649962;
  localparam logic [31:0] RST_DISPLAY_0 = 32'd41000;
  localparam logic [31:0] RST_DISPLAY_1 = 32'd285816;
  localparam logic [31:0] RST_DISPLAY_2 = 32'd163015;

  // solver quantities: determinant, then x numerators A,B,C, then y A,B,C
  localparam logic [2:0] Q_DET = 3'd0;
  localparam logic [2:0] Q_XA  = 3'd1;
  localparam logic [2:0] Q_XB  = 3'd2;
  localparam logic [2:0] Q_XC  = 3'd3;
  localparam logic [2:0] Q_YA  = 3'd4;
  localparam logic [2:0] Q_YB  = 3'd5;
  localparam logic [2:0] Q_YC  = 3'd6;

  localparam logic [2:0] LAST_TERM = 3'd5;

endpackage

/* hdl/touch_affine_calibration.sv */
// Touch affine calibration: maps raw touch x,y to display x,y with an affine
// map solved by Cramer's rule from three configured reference pairs.
// Fully pipelined: one word per cycle while the output is not stalled and the solver is idle.
// The map is set by a multiply, a sum, a sign/magnitude stage and one
// restoring divider stage per quotient bit, each with one lane per axis.
// After reset and after each write to a reference register (index up to
// REG_DISPLAY_2) the solver works out 7 quantities of 6 terms each, every
// term in a multiply, a second multiply and an accumulate phase through one
// multiplier pair; input ready stays low meanwhile. Reset is synchronous and loads the default reference pairs.
module touch_affine_calibration #(
  parameter int TOUCH_BITS   = 12,
  parameter int DISPLAY_BITS = 10
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write_en,
  input  logic [tac_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [2*((TOUCH_BITS > DISPLAY_BITS) ? TOUCH_BITS : DISPLAY_BITS)-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [TOUCH_BITS-1:0]            touch_x,
  input  logic [TOUCH_BITS-1:0]            touch_y,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [DISPLAY_BITS-1:0]          display_x,
  output logic [DISPLAY_BITS-1:0]          display_y,
  output logic                             mapping_valid
);
  import tac_pkg::*;

  localparam int TB = TOUCH_BITS;
  localparam int DB = DISPLAY_BITS;
  localparam int OW = (TB > DB) ? TB : DB;
  localparam int NW = 2 * TB + DB + 3;
  localparam int MW = NW + TB + 1;
  localparam int PW = NW + TB + 3;
  localparam int WW = PW + DB;
  localparam int L  = 3 + DB;

  typedef enum logic [1:0] {PH_MUL1, PH_MUL2, PH_ACC} phase_t;

  logic [2*TB-1:0] ref_t [3];
  logic [2*DB-1:0] ref_d [3];

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_t[0] <= RST_TOUCH_0[2*TB-1:0];
      ref_t[1] <= RST_TOUCH_1[2*TB-1:0];
      ref_t[2] <= RST_TOUCH_2[2*TB-1:0];
      ref_d[0] <= RST_DISPLAY_0[2*DB-1:0];
      ref_d[1] <= RST_DISPLAY_1[2*DB-1:0];
      ref_d[2] <= RST_DISPLAY_2[2*DB-1:0];
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_TOUCH_0:   ref_t[0] <= cfg_data[2*TB-1:0];
        REG_TOUCH_1:   ref_t[1] <= cfg_data[2*TB-1:0];
        REG_TOUCH_2:   ref_t[2] <= cfg_data[2*TB-1:0];
        REG_DISPLAY_0: ref_d[0] <= cfg_data[2*DB-1:0];
        REG_DISPLAY_1: ref_d[1] <= cfg_data[2*DB-1:0];
        REG_DISPLAY_2: ref_d[2] <= cfg_data[2*DB-1:0];
        default: ;
      endcase
    end
  end

  logic cfg_hit;
  assign cfg_hit = cfg_write_en && (cfg_index <= REG_DISPLAY_2);

  // solver
  function automatic logic [1:0] idx_next(input logic [1:0] i);
    unique case (i)
      2'd0:    idx_next = 2'd1;
      2'd1:    idx_next = 2'd2;
      default: idx_next = 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] idx_prev(input logic [1:0] i);
    unique case (i)
      2'd0:    idx_prev = 2'd2;
      2'd1:    idx_prev = 2'd0;
      default: idx_prev = 2'd1;
    endcase
  endfunction

  logic          solving;
  phase_t        phase;
  logic [2:0]    qty;
  logic [2:0]    term;
  logic [2*OW-1:0] p1;
  logic [3*OW-1:0] p2;
  logic signed [NW-1:0] acc;
  logic signed [NW-1:0] acc_next;
  logic signed [NW-1:0] det;
  logic signed [NW-1:0] num [6];

  logic [OW-1:0] xt [3];
  logic [OW-1:0] yt [3];
  logic [OW-1:0] dd [3];
  logic [1:0]    ti, tj, tk;
  logic [OW-1:0] op_a, op_b, op_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xt[i] = OW'(ref_t[i][2*TB-1:TB]);
      yt[i] = OW'(ref_t[i][TB-1:0]);
      dd[i] = (qty <= Q_XC) ? OW'(ref_d[i][2*DB-1:DB]) : OW'(ref_d[i][DB-1:0]);
    end
    ti = term[2:1];
    tj = term[0] ? idx_prev(ti) : idx_next(ti);
    tk = term[0] ? idx_next(ti) : idx_prev(ti);
    op_c = OW'(1);
    unique case (qty)
      Q_XA, Q_YA: begin
        op_a = dd[ti];
        op_b = yt[tj];
      end
      Q_XB, Q_YB: begin
        op_a = xt[ti];
        op_b = dd[tj];
      end
      Q_XC, Q_YC: begin
        op_a = xt[ti];
        op_b = yt[tj];
        op_c = dd[tk];
      end
      default: begin
        op_a = xt[ti];
        op_b = yt[tj];
      end
    endcase
    acc_next = term[0] ? acc - $signed(NW'(p2)) : acc + $signed(NW'(p2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      solving <= 1'b1;
      phase   <= PH_MUL1;
      qty     <= Q_DET;
      term    <= '0;
      acc     <= '0;
    end else if (cfg_hit) begin
      solving <= 1'b1;
      phase   <= PH_MUL1;
      qty     <= Q_DET;
      term    <= '0;
      acc     <= '0;
    end else if (solving) begin
      unique case (phase)
        PH_MUL1: begin
          p1    <= (2*OW)'(op_a) * (2*OW)'(op_b);
          phase <= PH_MUL2;
        end
        PH_MUL2: begin
          p2    <= (3*OW)'(p1) * (3*OW)'(op_c);
          phase <= PH_ACC;
        end
        default: begin
          phase <= PH_MUL1;
          if (term == LAST_TERM) begin
            if (qty == Q_DET) det <= acc_next;
            else num[qty - 3'd1] <= acc_next;
            acc  <= '0;
            term <= '0;
            qty  <= qty + 3'd1;
            if (qty == Q_YC) solving <= 1'b0;
          end else begin
            acc  <= acc_next;
            term <= term + 3'd1;
          end
        end
      endcase
    end
  end

  logic          det_nz;
  logic          det_neg;
  logic [NW-1:0] det_mag;
  assign det_nz  = (det != '0);
  assign det_neg = det[NW-1];
  assign det_mag = det_neg ? NW'(-det) : NW'(det);

  // mapping pipeline
  logic [L-1:0] v;
  logic [L-1:0] en;

  always_comb begin
    en[L-1] = !v[L-1] || out_ready;
    for (int s = L - 2; s >= 0; s--) en[s] = !v[s] || en[s+1];
  end

  assign in_ready = en[0] && !solving;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid && !solving;
      for (int s = 1; s < L; s++) begin
        if (en[s]) v[s] <= v[s-1];
      end
    end
  end

  logic signed [MW-1:0] tx_s, ty_s;
  assign tx_s = MW'($signed({1'b0, touch_x}));
  assign ty_s = MW'($signed({1'b0, touch_y}));

  logic signed [MW-1:0] pa [2];
  logic signed [MW-1:0] pb [2];
  logic signed [PW-1:0] nsum [2];
  logic [WW-1:0] rem [DB+1][2];
  logic [DB-1:0] quo [DB+1][2];
  logic          clr [DB+1][2];
  logic          ovr [DB+1][2];
  logic [PW-1:0] nabs [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      nabs[a] = nsum[a][PW-1] ? PW'(-nsum[a]) : PW'(nsum[a]);
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 2; a++) begin
      if (en[0]) begin
        pa[a] <= MW'(num[3*a]) * tx_s;
        pb[a] <= MW'(num[3*a+1]) * ty_s;
      end
      if (en[1]) begin
        nsum[a] <= PW'(pa[a]) + PW'(pb[a]) + PW'(num[3*a+2]);
      end
      if (en[2]) begin
        rem[0][a] <= WW'(nabs[a]);
        quo[0][a] <= '0;
        clr[0][a] <= nsum[a][PW-1] ^ det_neg;
        ovr[0][a] <= WW'(nabs[a]) >= (WW'(det_mag) << DB);
      end
    end
  end

  for (genvar s = 0; s < DB; s++) begin : g_div
    logic [WW-1:0] dsh;
    logic          ge [2];
    assign dsh = WW'(det_mag) << (DB - 1 - s);
    always_comb begin
      for (int a = 0; a < 2; a++) ge[a] = rem[s][a] >= dsh;
    end
    always_ff @(posedge clk) begin
      if (en[3+s]) begin
        for (int a = 0; a < 2; a++) begin
          rem[s+1][a] <= ge[a] ? rem[s][a] - dsh : rem[s][a];
          quo[s+1][a] <= quo[s][a] | (DB'(ge[a]) << (DB - 1 - s));
          clr[s+1][a] <= clr[s][a];
          ovr[s+1][a] <= ovr[s][a];
        end
      end
    end
  end

  logic [DB-1:0] res [2];
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      if (!det_nz || clr[DB][a]) res[a] = '0;
      else if (ovr[DB][a]) res[a] = '1;
      else res[a] = quo[DB][a];
    end
  end

  assign out_valid     = v[L-1];
  assign display_x     = res[0];
  assign display_y     = res[1];
  assign mapping_valid = det_nz;

  a_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> solving && qty == Q_DET)
    else $error("solver did not restart after register write");

  a_no_accept_solving: assert property (@(posedge clk) disable iff (rst)
    solving |-> !in_ready)
    else $error("input taken while solving");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !mapping_valid |-> display_x == '0 && display_y == '0)
    else $error("nonzero coordinates with degenerate map");

endmodule

/* tb/tb_touch_affine_calibration.sv */
// Testbench for touch_affine_calibration: maps raw touch words through an
// affine calibration predicted here in exact integers and checks each word.
// Depends on tac_pkg and the touch_affine_calibration RTL.
module tb_touch_affine_calibration;
  timeunit 1ns;
  timeprecision 1ps;
  import tac_pkg::*;

  typedef struct packed {
    logic [9:0] dx;
    logic [9:0] dy;
    logic       ok;
  } display_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [11:0] touch_x = '0;
  logic [11:0] touch_y = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [9:0]  display_x;
  logic [9:0]  display_y;
  logic        mapping_valid;

  touch_affine_calibration i_dut (.*);

  always #5 clk = ~clk;

  // calibration copy and solved map
  logic [23:0]    cal_regs [6];
  longint         cal_det;
  longint         cal_num [6];
  bit             cal_current;
  display_word_t  expected_words [$];
  int             send_idle_pct, recv_idle_pct;
  int             errors, stall_cycles;
  bit             finished;

  function automatic longint det3(longint a1, a2, a3, b1, b2, b3);
    return a1 * (b2 - b3) + a2 * (b3 - b1) + a3 * (b1 - b2);
  endfunction

  task automatic solve_calibration();
    longint xt [3], yt [3], xd [3], yd [3];
    for (int i = 0; i < 3; i++) begin
      xt[i] = cal_regs[i][23:12];
      yt[i] = cal_regs[i][11:0];
      xd[i] = cal_regs[3+i][19:10];
      yd[i] = cal_regs[3+i][9:0];
    end
    cal_det = det3(xt[0], xt[1], xt[2], yt[0], yt[1], yt[2]);
    for (int a = 0; a < 2; a++) begin
      longint d [3];
      for (int i = 0; i < 3; i++) d[i] = a ? yd[i] : xd[i];
      cal_num[3*a]   = det3(d[0], d[1], d[2], yt[0], yt[1], yt[2]);
      cal_num[3*a+1] = det3(xt[0], xt[1], xt[2], d[0], d[1], d[2]);
      cal_num[3*a+2] = xt[0] * (yt[1] * d[2] - yt[2] * d[1])
                     + xt[1] * (yt[2] * d[0] - yt[0] * d[2])
                     + xt[2] * (yt[0] * d[1] - yt[1] * d[0]);
    end
    cal_current = 1'b1;
  endtask

  function automatic logic [9:0] map_axis(int a, longint tx, longint ty);
    longint q;
    q = (cal_num[3*a] * tx + cal_num[3*a+1] * ty + cal_num[3*a+2]) / cal_det;
    if (q < 0) return 10'd0;
    if (q > 1023) return 10'd1023;
    return q[9:0];
  endfunction

  // hold the write enable; the caller drops it after the last write
  task automatic write_reg(logic [2:0] idx, logic [23:0] value);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= value;
    @(posedge clk);
    if (idx <= REG_DISPLAY_2) begin
      cal_regs[idx] = (idx <= REG_TOUCH_2) ? value : {4'd0, value[19:0]};
      cal_current = 1'b0;
    end
  endtask

  task automatic end_writes();
    cfg_write_en <= 1'b0;
  endtask

  // hold valid into the next word unless the sender idles
  task automatic send_touch(logic [11:0] tx, logic [11:0] ty);
    display_word_t w;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    if (!cal_current) solve_calibration();
    if (cal_det == 0) w = '0;
    else w = '{dx: map_axis(0, tx, ty), dy: map_axis(1, tx, ty), ok: 1'b1};
    expected_words.push_back(w);
    in_valid <= 1'b1;
    touch_x  <= tx;
    touch_y  <= ty;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_calibration(logic [23:0] t0, t1, t2, logic [19:0] d0, d1, d2);
    drain();
    write_reg(REG_TOUCH_0, t0);
    write_reg(REG_TOUCH_1, t1);
    write_reg(REG_TOUCH_2, t2);
    write_reg(REG_DISPLAY_0, {4'd0, d0});
    write_reg(REG_DISPLAY_1, {4'd0, d1});
    write_reg(REG_DISPLAY_2, {4'd0, d2});
    end_writes();
  endtask

  // receiver side: stall at random, compare each word with the oldest prediction
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        display_word_t w;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word x=%0d y=%0d v=%0d", $time,
                   display_x, display_y, mapping_valid);
          errors++;
        end else begin
          w = expected_words.pop_front();
          if (w.dx !== display_x || w.dy !== display_y || w.ok !== mapping_valid) begin
            $display("%0t: expected x=%0d y=%0d v=%0d, actual x=%0d y=%0d v=%0d",
                     $time, w.dx, w.dy, w.ok, display_x, display_y, mapping_valid);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else if (!finished) stall_cycles++;
      if (stall_cycles > 20000) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic test_directed_defaults();
    send_touch(12'd0, 12'd0);
    send_touch(12'hFFF, 12'hFFF);
    send_touch(12'hFFF, 12'd0);
    send_touch(12'd0, 12'hFFF);
    send_touch(12'h2F4, 12'h421);
    send_touch(12'hAAA, 12'h555);
    send_touch(12'h555, 12'hAAA);
  endtask

  task automatic test_degenerate();
    set_calibration(24'h100100, 24'h200200, 24'h300300, 20'd0, 20'hFFFFF, 20'h12345);
    send_touch(12'd5, 12'd7);
    send_touch(12'hFFF, 12'hFFF);
    set_calibration('0, '0, '0, '0, '0, '0);
    send_touch(12'd1, 12'd2);
  endtask

  task automatic test_extremes();
    set_calibration(24'h000000, 24'hFFF000, 24'h000FFF, 20'hFFFFF, 20'h00000, 20'hFFC00);
    send_touch(12'd0, 12'd0);
    send_touch(12'hFFF, 12'hFFF);
    send_touch(12'h800, 12'h800);
    set_calibration(24'hFFFFFF, 24'h000FFF, 24'hFFF000, 20'h00000, 20'h003FF, 20'hFFFFF);
    send_touch(12'd0, 12'd0);
    send_touch(12'hFFF, 12'h000);
    // ignored index leaves the map alone
    drain();
    write_reg(3'd6, 24'hFFFFFF);
    write_reg(3'd7, 24'h123456);
    end_writes();
    send_touch(12'h123, 12'hFED);
  endtask

  task automatic test_random(int items);
    for (int n = 0; n < items; n++) begin
      if (n % 200 == 0) begin
        logic [23:0] t [3];
        logic [19:0] d [3];
        for (int i = 0; i < 3; i++) begin
          t[i] = 24'($urandom);
          d[i] = 20'($urandom);
        end
        if (n % 400 == 200) t[2] = t[1];
        set_calibration(t[0], t[1], t[2], d[0], d[1], d[2]);
        // single register rewrite mid-phase, unmasked upper data bits
        if (n % 600 == 0) begin
          drain();
          write_reg(3'($urandom_range(5)), 24'($urandom));
          end_writes();
        end
      end
      if (n == items / 2) drain();
      send_touch(12'($urandom), 12'($urandom));
    end
  endtask

  initial begin
    cal_regs[0] = RST_TOUCH_0[23:0];
    cal_regs[1] = RST_TOUCH_1[23:0];
    cal_regs[2] = RST_TOUCH_2[23:0];
    cal_regs[3] = RST_DISPLAY_0[23:0];
    cal_regs[4] = RST_DISPLAY_1[23:0];
    cal_regs[5] = RST_DISPLAY_2[23:0];
    cal_current = 1'b0;
    send_idle_pct = 34;
    recv_idle_pct = 75;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_defaults();
    test_degenerate();
    test_extremes();
    test_random(550);
    send_idle_pct = 75;
    recv_idle_pct = 34;
    test_random(550);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(500);
    drain();
    finished = 1'b1;
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
